// ===== sv/dmf_pkg.sv =====
`timescale 1ns / 1ps

package dmf_pkg;

    localparam int NODE_W     = 6;
    localparam int CAP_IN_W   = 32;
    localparam int FLOW_W     = 48;
    localparam int NCOUNT_W   = 7;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 2;

    localparam logic [FLOW_W-1:0] FLOW_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NODE_COUNT = 2'd0,
        REG_SOURCE     = 2'd1,
        REG_SINK       = 2'd2
    } dmf_reg_t;

    typedef struct packed {
        logic                action;
        logic [NODE_W-1:0]   from_node;
        logic [NODE_W-1:0]   to_node;
        logic [CAP_IN_W-1:0] capacity;
    } dmf_in_t;

    typedef struct packed {
        logic [FLOW_W-1:0] max_flow;
        logic              saturated;
    } dmf_out_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD,
        S_START,
        S_BINIT,
        S_BSEED,
        S_BPOP,
        S_BU,
        S_BLU,
        S_BSCAN,
        S_BCHK,
        S_BEND,
        S_BSNK,
        S_PINIT,
        S_FLOAD,
        S_FLOADED,
        S_FSCAN,
        S_FCHK,
        S_ARD,
        S_AWR1,
        S_AWR2,
        S_POP,
        S_POPW,
        S_POPL,
        S_PEND,
        S_FINISH
    } dmf_state_t;

    typedef struct packed {
        dmf_state_t op;
        logic       in_ready;
        logic       in_take;
    } dmf_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_action;
        logic range_ok;
        logic same_node;
        logic clr_last;
        logic init_last;
        logic q_empty;
        logic w_last;
        logic snk_unr;
        logic ep_end;
        logic chk_ok;
        logic chk_sink;
        logic cap_zero;
        logic depth_one;
        logic out_busy;
    } dmf_stat_t;

endpackage

// ===== sv/dense_max_flow.sv =====
`timescale 1ns / 1ps

// dense maximum flow (level graph plus blocking-flow pushes) over a residual matrix
// input beats: action 0 adds capacity to the pair from_node -> to_node, saturating;
// action 1 runs the flow computation on the current graph and then clears it
// an add beat reads one matrix entry, then writes the saturated sum back to it
// a compute beat gives one result beat; its time depends on the graph: each level
// pass resets the labels and scans the matrix row of each reached node, and each
// push step spends its time on edge visits and flow updates
// after each result the matrix is swept clear, one entry a cycle, all 2^(2*ceil(log2
// MAX_NODES)) entries, 4096 by default; the same sweep runs after reset
// in_ready is low from a compute beat until its clearing sweep has ended
// the result sits in an output register until taken; a stalled receiver only holds
// the block once the next compute result is ready to be written
// configuration writes are taken on any cycle with cfg_we high
module dense_max_flow #(
    parameter int MAX_NODES = 64,
    parameter int CAP_WIDTH = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  dmf_pkg::dmf_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output dmf_pkg::dmf_out_t             out_data,
    input  logic                          cfg_we,
    input  logic [dmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dmf_pkg::CFG_W-1:0]     cfg_data
);
    import dmf_pkg::*;

    dmf_cmd_t  cmd;
    dmf_stat_t stat;

    dmf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    dmf_dp #(
        .MAX_NODES (MAX_NODES),
        .CAP_WIDTH (CAP_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    assign in_ready = cmd.in_ready;

endmodule

// ===== sv/dmf_ram.sv =====
`timescale 1ns / 1ps

module dmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/dmf_ctrl.sv =====
`timescale 1ns / 1ps

module dmf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  dmf_pkg::dmf_stat_t stat,
    output dmf_pkg::dmf_cmd_t  cmd
);
    import dmf_pkg::*;

    dmf_state_t state_reg;
    dmf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:   if (stat.clr_last) state_next = S_IDLE;
            S_IDLE:
            begin
                if (stat.in_valid)
                begin
                    state_next = stat.in_action ? S_START : S_ADD;
                end
            end
            S_ADD:     state_next = S_IDLE;
            S_START:
            begin
                if (!stat.range_ok || stat.same_node)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_BINIT;
                end
            end
            S_BINIT:   if (stat.init_last) state_next = S_BSEED;
            S_BSEED:   state_next = S_BPOP;
            S_BPOP:    state_next = stat.q_empty ? S_BEND : S_BU;
            S_BU:      state_next = S_BLU;
            S_BLU:     state_next = S_BSCAN;
            S_BSCAN:   state_next = S_BCHK;
            S_BCHK:    state_next = stat.w_last ? S_BPOP : S_BSCAN;
            S_BEND:    state_next = S_BSNK;
            S_BSNK:    state_next = stat.snk_unr ? S_FINISH : S_PINIT;
            S_PINIT:   state_next = S_FLOAD;
            S_FLOAD:   state_next = S_FLOADED;
            S_FLOADED: state_next = S_FSCAN;
            S_FSCAN:   state_next = stat.ep_end ? S_POP : S_FCHK;
            S_FCHK:
            begin
                if (!stat.chk_ok)
                begin
                    state_next = S_FSCAN;
                end
                else if (stat.chk_sink)
                begin
                    state_next = S_ARD;
                end
                else
                begin
                    state_next = S_FLOAD;
                end
            end
            S_ARD:     state_next = S_AWR1;
            S_AWR1:    state_next = S_AWR2;
            S_AWR2:    state_next = stat.cap_zero ? S_POP : S_FSCAN;
            S_POP:     state_next = stat.depth_one ? S_PEND : S_POPW;
            S_POPW:    state_next = S_POPL;
            S_POPL:    state_next = S_ARD;
            S_PEND:    state_next = S_BINIT;
            S_FINISH:  if (!stat.out_busy) state_next = S_CLEAR;
            default:   state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd.op       = state_reg;
        cmd.in_ready = (state_reg == S_IDLE);
        cmd.in_take  = (state_reg == S_IDLE) && stat.in_valid;
    end

endmodule

// ===== sv/dmf_dp.sv =====
`timescale 1ns / 1ps

module dmf_dp #(
    parameter int MAX_NODES = 64,
    parameter int CAP_WIDTH = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dmf_pkg::dmf_cmd_t                   cmd,
    output dmf_pkg::dmf_stat_t                  stat,
    input  logic                                in_valid,
    input  dmf_pkg::dmf_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output dmf_pkg::dmf_out_t                   out_data,
    input  logic                                cfg_we,
    input  logic [dmf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dmf_pkg::CFG_W-1:0]           cfg_data
);
    import dmf_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int N1  = NW + 1;
    localparam int CW  = CAP_WIDTH;
    localparam int SW  = CW + NW + 1;
    localparam int LW  = NW + 1;
    localparam int MAW = 2 * NW;
    localparam int FW  = NW + CW + SW;
    localparam int GW  = (SW > FLOW_W) ? SW : FLOW_W;
    localparam logic [LW-1:0] UNR     = '1;
    localparam logic [CW-1:0] CAP_MAX = '1;

    function automatic logic [NW-1:0] node_idx(input logic [NODE_W-1:0] x);
        logic [31:0] t;
        t = 32'(x);
        return t[NW-1:0];
    endfunction

    // top bit flags saturation
    function automatic logic [CW:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[CW])
        begin
            s = {1'b1, CAP_MAX};
        end
        return s;
    endfunction

    // configuration
    logic [NCOUNT_W-1:0] ncfg_reg, ncfg_next;
    logic [NODE_W-1:0]   srccfg_reg, srccfg_next;
    logic [NODE_W-1:0]   snkcfg_reg, snkcfg_next;

    logic            add_ok_reg, add_ok_next;
    logic [MAW-1:0]  add_addr_reg, add_addr_next;
    logic [CAP_IN_W-1:0] add_cap_reg, add_cap_next;

    logic [FLOW_W-1:0] total_reg, total_next;
    logic              ovf_reg, ovf_next;
    logic [MAW-1:0]    clr_reg, clr_next;
    logic [NW:0]       n_reg, n_next;
    logic [NW:0]       cnt_reg, cnt_next;
    logic [NW:0]       head_reg, head_next;
    logic [NW:0]       tail_reg, tail_next;
    logic [NW-1:0]     u_reg, u_next;
    logic [LW-1:0]     lvl_u_reg, lvl_u_next;
    logic [NW-1:0]     v_reg, v_next;
    logic [CW-1:0]     cap_reg, cap_next;
    logic [SW-1:0]     sum_reg, sum_next;
    logic [NW:0]       depth_reg, depth_next;
    logic [NW:0]       ep_reg, ep_next;
    logic [LW-1:0]     lvl_v_reg, lvl_v_next;
    logic [SW-1:0]     ret_reg, ret_next;
    dmf_out_t          out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    // memory ports
    logic           mat_we;
    logic [MAW-1:0] mat_waddr, mat_raddr;
    logic [CW-1:0]  mat_wdata, mat_rdata;
    logic           lvl_we;
    logic [NW-1:0]  lvl_waddr, lvl_raddr;
    logic [LW-1:0]  lvl_wdata, lvl_rdata;
    logic           ep_we;
    logic [NW-1:0]  ep_waddr, ep_raddr;
    logic [NW:0]    ep_wdata, ep_rdata;
    logic           q_we;
    logic [NW-1:0]  q_waddr, q_raddr;
    logic [NW-1:0]  q_wdata, q_rdata;
    logic           stk_we;
    logic [NW-1:0]  stk_waddr, stk_raddr;
    logic [FW-1:0]  stk_wdata, stk_rdata;

    dmf_ram #(.WIDTH(CW), .DEPTH(1 << MAW)) u_mat (
        .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
        .raddr(mat_raddr), .rdata(mat_rdata)
    );
    dmf_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_lvl (
        .clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
        .raddr(lvl_raddr), .rdata(lvl_rdata)
    );
    dmf_ram #(.WIDTH(N1), .DEPTH(MAX_NODES)) u_ep (
        .clk(clk), .we(ep_we), .waddr(ep_waddr), .wdata(ep_wdata),
        .raddr(ep_raddr), .rdata(ep_rdata)
    );
    dmf_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_q (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );
    dmf_ram #(.WIDTH(FW), .DEPTH(MAX_NODES)) u_stk (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    logic [NW-1:0]  src_n, snk_n, w_idx, cw_idx, stk_node;
    logic [CW-1:0]  stk_cap;
    logic [SW-1:0]  stk_sum;
    logic [MAW-1:0] in_addr;
    logic [NW:0]    dm1, dm2;
    logic           root, bfs_hit, chk_ok, chk_sink, add_in_ok;
    logic [CW-1:0]  c_min, ret_cw;
    logic [CW:0]    sat_in, sat_rev;
    logic [31:0]    ncount32;
    logic [GW-1:0]  got_ext, room_ext;

    always_comb
    begin
        src_n     = node_idx(srccfg_reg);
        snk_n     = node_idx(snkcfg_reg);
        w_idx     = ep_reg[NW-1:0];
        cw_idx    = cnt_reg[NW-1:0];
        stk_node  = stk_rdata[FW-1 -: NW];
        stk_cap   = stk_rdata[SW +: CW];
        stk_sum   = stk_rdata[SW-1:0];
        in_addr   = {node_idx(in_data.from_node), node_idx(in_data.to_node)};
        add_in_ok = (32'(in_data.from_node) < MAX_NODES) && (32'(in_data.to_node) < MAX_NODES);
        ncount32  = 32'(ncfg_reg);
        dm1       = depth_reg - 1'b1;
        dm2       = depth_reg - 2'd2;
        root      = (depth_reg == N1'(1));
        ret_cw    = ret_reg[CW-1:0];
        c_min     = (!root && (cap_reg < mat_rdata)) ? cap_reg : mat_rdata;
        bfs_hit   = (mat_rdata != '0) && (lvl_rdata == UNR);
        chk_ok    = (lvl_v_reg != UNR) && (lvl_rdata == LW'(lvl_v_reg + 1'b1))
                    && (mat_rdata != '0);
        chk_sink  = (w_idx == snk_n);
        sat_in    = sat_add(mat_rdata, CW'(add_cap_reg));
        sat_rev   = sat_add(mat_rdata, ret_cw);
        got_ext   = GW'(ret_reg);
        room_ext  = GW'(FLOW_MAX - total_reg);
    end

    always_comb
    begin
        stat.in_valid  = in_valid;
        stat.in_action = in_data.action;
        stat.range_ok  = (32'(srccfg_reg) < 32'(n_reg)) && (32'(snkcfg_reg) < 32'(n_reg));
        stat.same_node = (srccfg_reg == snkcfg_reg);
        stat.clr_last  = (clr_reg == '1);
        stat.init_last = (cnt_reg == n_reg - 1'b1);
        stat.q_empty   = (head_reg == tail_reg);
        stat.w_last    = (cnt_reg == n_reg - 1'b1);
        stat.snk_unr   = (lvl_rdata == UNR);
        stat.ep_end    = (ep_reg >= n_reg);
        stat.chk_ok    = chk_ok;
        stat.chk_sink  = chk_sink;
        stat.cap_zero  = !root && (cap_reg == ret_cw);
        stat.depth_one = (depth_reg == N1'(1));
        stat.out_busy  = out_valid_reg && !out_ready;
    end

    // memory addressing per step
    always_comb
    begin
        mat_we = 1'b0; mat_waddr = clr_reg; mat_wdata = '0; mat_raddr = in_addr;
        lvl_we = 1'b0; lvl_waddr = cw_idx; lvl_wdata = UNR; lvl_raddr = cw_idx;
        ep_we = 1'b0; ep_waddr = cw_idx; ep_wdata = '0; ep_raddr = v_reg;
        q_we = 1'b0; q_waddr = tail_reg[NW-1:0]; q_wdata = cw_idx;
        q_raddr = head_reg[NW-1:0];
        stk_we = 1'b0; stk_waddr = dm1[NW-1:0]; stk_wdata = {v_reg, cap_reg, sum_reg};
        stk_raddr = dm2[NW-1:0];
        case (cmd.op)
            S_CLEAR:
            begin
                mat_we = 1'b1;
            end
            S_ADD:
            begin
                mat_we    = add_ok_reg;
                mat_waddr = add_addr_reg;
                mat_wdata = sat_in[CW-1:0];
            end
            S_BINIT:
            begin
                lvl_we = 1'b1;
                ep_we  = 1'b1;
            end
            S_BSEED:
            begin
                lvl_we    = 1'b1;
                lvl_waddr = src_n;
                lvl_wdata = '0;
                q_we      = 1'b1;
                q_waddr   = '0;
                q_wdata   = src_n;
            end
            S_BU:
            begin
                lvl_raddr = q_rdata;
            end
            S_BSCAN:
            begin
                mat_raddr = {u_reg, cw_idx};
            end
            S_BCHK:
            begin
                lvl_we    = bfs_hit;
                lvl_wdata = lvl_u_reg + 1'b1;
                q_we      = bfs_hit;
            end
            S_BEND:
            begin
                lvl_raddr = snk_n;
            end
            S_FLOAD:
            begin
                lvl_raddr = v_reg;
            end
            S_FSCAN, S_ARD:
            begin
                mat_raddr = {v_reg, w_idx};
                lvl_raddr = w_idx;
            end
            S_FCHK:
            begin
                ep_we    = chk_ok && !chk_sink;
                ep_waddr = v_reg;
                ep_wdata = ep_reg;
                stk_we   = chk_ok && !chk_sink;
            end
            S_AWR1:
            begin
                mat_we    = 1'b1;
                mat_waddr = {v_reg, w_idx};
                mat_wdata = mat_rdata - ret_cw;
                mat_raddr = {w_idx, v_reg};
            end
            S_AWR2:
            begin
                mat_we    = 1'b1;
                mat_waddr = {w_idx, v_reg};
                mat_wdata = sat_rev[CW-1:0];
            end
            S_POP:
            begin
                ep_we    = 1'b1;
                ep_waddr = v_reg;
                ep_wdata = ep_reg;
            end
            S_POPW:
            begin
                lvl_raddr = stk_node;
                ep_raddr  = stk_node;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        ncfg_next      = ncfg_reg;
        srccfg_next    = srccfg_reg;
        snkcfg_next    = snkcfg_reg;
        add_ok_next    = add_ok_reg;
        add_addr_next  = add_addr_reg;
        add_cap_next   = add_cap_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        clr_next       = clr_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        u_next         = u_reg;
        lvl_u_next     = lvl_u_reg;
        v_next         = v_reg;
        cap_next       = cap_reg;
        sum_next       = sum_reg;
        depth_next     = depth_reg;
        ep_next        = ep_reg;
        lvl_v_next     = lvl_v_reg;
        ret_next       = ret_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_NODE_COUNT: ncfg_next   = cfg_data[NCOUNT_W-1:0];
                REG_SOURCE:     srccfg_next = cfg_data[NODE_W-1:0];
                REG_SINK:       snkcfg_next = cfg_data[NODE_W-1:0];
                default:        ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (cmd.op)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (cmd.in_take)
                begin
                    add_ok_next   = add_in_ok;
                    add_addr_next = in_addr;
                    add_cap_next  = in_data.capacity;
                    n_next = (ncount32 > MAX_NODES) ? N1'(MAX_NODES) : N1'(ncount32);
                end
            end
            S_ADD:
            begin
                if (add_ok_reg && sat_in[CW])
                begin
                    ovf_next = 1'b1;
                end
            end
            S_START:
            begin
                cnt_next = '0;
                if (stat.range_ok && stat.same_node)
                begin
                    total_next = FLOW_MAX;
                    ovf_next   = 1'b1;
                end
            end
            S_BINIT:
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            S_BSEED:
            begin
                head_next = '0;
                tail_next = N1'(1);
            end
            S_BPOP:
            begin
                if (!stat.q_empty)
                begin
                    head_next = head_reg + 1'b1;
                end
            end
            S_BU:
            begin
                u_next = q_rdata;
            end
            S_BLU:
            begin
                lvl_u_next = lvl_rdata;
                cnt_next   = '0;
            end
            S_BCHK:
            begin
                if (bfs_hit)
                begin
                    tail_next = tail_reg + 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
            end
            S_PINIT:
            begin
                v_next     = src_n;
                cap_next   = CAP_MAX;
                sum_next   = '0;
                depth_next = N1'(1);
            end
            S_FLOADED, S_POPL:
            begin
                ep_next    = ep_rdata;
                lvl_v_next = lvl_rdata;
            end
            S_FCHK:
            begin
                if (!chk_ok)
                begin
                    ep_next = ep_reg + 1'b1;
                end
                else if (chk_sink)
                begin
                    ret_next = SW'(c_min);
                end
                else
                begin
                    v_next     = w_idx;
                    cap_next   = c_min;
                    sum_next   = '0;
                    depth_next = depth_reg + 1'b1;
                end
            end
            S_AWR2:
            begin
                if (sat_rev[CW])
                begin
                    ovf_next = 1'b1;
                end
                sum_next = sum_reg + SW'(ret_cw);
                if (!root)
                begin
                    cap_next = cap_reg - ret_cw;
                end
                if (!stat.cap_zero)
                begin
                    ep_next = ep_reg + 1'b1;
                end
            end
            S_POP:
            begin
                ret_next   = sum_reg;
                depth_next = dm1;
            end
            S_POPW:
            begin
                v_next   = stk_node;
                cap_next = stk_cap;
                sum_next = stk_sum;
            end
            S_PEND:
            begin
                cnt_next = '0;
                if (got_ext > room_ext)
                begin
                    total_next = FLOW_MAX;
                    ovf_next   = 1'b1;
                end
                else
                begin
                    total_next = total_reg + FLOW_W'(ret_reg);
                end
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    out_next.max_flow  = total_reg;
                    out_next.saturated = ovf_reg;
                    out_valid_next     = 1'b1;
                    total_next         = '0;
                    ovf_next           = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncfg_reg      <= NCOUNT_W'(64);
            srccfg_reg    <= '0;
            snkcfg_reg    <= NODE_W'(1);
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            clr_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ncfg_reg      <= ncfg_next;
            srccfg_reg    <= srccfg_next;
            snkcfg_reg    <= snkcfg_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            clr_reg       <= clr_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        add_ok_reg   <= add_ok_next;
        add_addr_reg <= add_addr_next;
        add_cap_reg  <= add_cap_next;
        n_reg        <= n_next;
        cnt_reg      <= cnt_next;
        u_reg        <= u_next;
        lvl_u_reg    <= lvl_u_next;
        v_reg        <= v_next;
        cap_reg      <= cap_next;
        sum_reg      <= sum_next;
        ep_reg       <= ep_next;
        lvl_v_reg    <= lvl_v_next;
        ret_reg      <= ret_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // level graph bounds the frame stack by the node count
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == S_FCHK && chk_ok && !chk_sink) |-> (depth_reg < n_reg))
        else $error("frame stack deeper than node count");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    a_pop_parent: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == S_POPW) |-> (depth_reg != '0))
        else $error("parent reload with empty stack");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == S_FINISH && !stat.out_busy) |=> out_valid_reg)
        else $error("finished compute gave no result beat");

endmodule

// ===== tb/dense_max_flow_tb.sv =====
`timescale 1ns / 1ps

module dense_max_flow_tb;
    import dmf_pkg::*;

    localparam int NODES      = 64;
    localparam int SWEEP_WAIT = 4300;
    localparam int QUIET_MAX  = 120000;
    localparam bit [63:0] ENTRY_MAX = 64'h0000_FFFF_FFFF_FFFF;
    localparam bit [63:0] NO_LIMIT  = '1;
    localparam int unsigned UNREACHED = 32'hFFFF_FFFF;
    localparam bit ACT_ADD     = 1'b0;
    localparam bit ACT_COMPUTE = 1'b1;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    dmf_in_t              in_data;
    logic                 out_valid;
    logic                 out_ready;
    dmf_out_t             out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    dense_max_flow i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the block: configuration, residual matrix and flow state
    int unsigned  node_limit;
    int unsigned  src_node;
    int unsigned  snk_node;
    bit [63:0]    resid [NODES*NODES];
    int unsigned  lvl [NODES];
    int unsigned  eptr [NODES];
    int unsigned  bq [NODES];
    int unsigned  fnode [NODES+1];
    bit [63:0]    fcap [NODES+1];
    bit [63:0]    fsum [NODES+1];
    bit [63:0]    flow_total;
    bit           flow_ovf;

    dmf_in_t      pending_beats[$];
    dmf_out_t     flow_expected[$];
    int           errors;
    int           add_beats;
    int           flows_checked;
    int           send_idle;
    int           recv_stall;
    int           hold_cnt;
    int           quiet;
    logic         in_done;

    function automatic bit [63:0] sat_add(bit [63:0] a, bit [63:0] b);
        if (a > ENTRY_MAX || b > ENTRY_MAX - a)
        begin
            flow_ovf = 1'b1;
            return ENTRY_MAX;
        end
        return a + b;
    endfunction

    function automatic void clear_graph();
        for (int i = 0; i < NODES*NODES; i++)
            resid[i] = '0;
        for (int i = 0; i < NODES; i++)
        begin
            lvl[i] = UNREACHED;
            eptr[i] = 0;
        end
        flow_total = '0;
        flow_ovf = 1'b0;
    endfunction

    function automatic bit label_levels(int unsigned n, int unsigned src, int unsigned snk);
        int unsigned head;
        int unsigned tail;
        int unsigned u;
        head = 0;
        tail = 0;
        for (int unsigned i = 0; i < n; i++)
        begin
            lvl[i] = UNREACHED;
            eptr[i] = 0;
        end
        lvl[src] = 0;
        bq[tail++] = src;
        while (head < tail)
        begin
            u = bq[head++];
            for (int unsigned w = 0; w < n; w++)
                if (resid[u*NODES+w] != 0 && lvl[w] == UNREACHED)
                begin
                    lvl[w] = lvl[u] + 1;
                    if (tail < NODES)
                        bq[tail++] = w;
                end
        end
        return lvl[snk] != UNREACHED;
    endfunction

    // one blocking-flow pass with an explicit frame stack
    function automatic bit [63:0] push_pass(int unsigned n, int unsigned src,
                                            int unsigned snk);
        int unsigned depth;
        int unsigned v;
        int unsigned w;
        int unsigned pv;
        bit [63:0]   ret;
        bit [63:0]   r;
        bit [63:0]   c;
        bit          descended;
        fnode[0] = src;
        fcap[0] = NO_LIMIT;
        fsum[0] = '0;
        depth = 1;
        while (1)
        begin
            v = fnode[depth-1];
            descended = 1'b0;
            while (eptr[v] < n)
            begin
                w = eptr[v];
                r = resid[v*NODES+w];
                if (lvl[v] != UNREACHED && lvl[w] == lvl[v] + 1 && r != 0)
                begin
                    c = (fcap[depth-1] < r) ? fcap[depth-1] : r;
                    if (w == snk)
                        ret = c;
                    else if (depth <= NODES)
                    begin
                        fnode[depth] = w;
                        fcap[depth] = c;
                        fsum[depth] = '0;
                        depth++;
                        descended = 1'b1;
                        break;
                    end
                    else
                        ret = '0;
                    resid[v*NODES+w] -= ret;
                    resid[w*NODES+v] = sat_add(resid[w*NODES+v], ret);
                    fsum[depth-1] += ret;
                    fcap[depth-1] -= ret;
                    if (fcap[depth-1] == 0)
                        break;
                end
                eptr[v]++;
            end
            if (!descended)
            begin
                ret = fsum[depth-1];
                depth--;
                while (1)
                begin
                    if (depth == 0)
                        return ret;
                    pv = fnode[depth-1];
                    w = eptr[pv];
                    resid[pv*NODES+w] -= ret;
                    resid[w*NODES+pv] = sat_add(resid[w*NODES+pv], ret);
                    fsum[depth-1] += ret;
                    fcap[depth-1] -= ret;
                    if (fcap[depth-1] == 0)
                    begin
                        ret = fsum[depth-1];
                        depth--;
                    end
                    else
                    begin
                        eptr[pv]++;
                        break;
                    end
                end
            end
        end
        return '0;
    endfunction

    function automatic void apply_beat(dmf_in_t b);
        int unsigned n;
        bit [63:0]   got;
        dmf_out_t    res;
        if (b.action == ACT_ADD)
        begin
            resid[b.from_node*NODES+b.to_node] =
                sat_add(resid[b.from_node*NODES+b.to_node], 64'(b.capacity));
            return;
        end
        n = (node_limit > NODES) ? NODES : node_limit;
        if (src_node < n && snk_node < n)
        begin
            if (src_node == snk_node)
            begin
                flow_total = 64'(FLOW_MAX);
                flow_ovf = 1'b1;
            end
            else
                while (label_levels(n, src_node, snk_node))
                begin
                    got = push_pass(n, src_node, snk_node);
                    if (got > 64'(FLOW_MAX) - flow_total)
                    begin
                        flow_total = 64'(FLOW_MAX);
                        flow_ovf = 1'b1;
                    end
                    else
                        flow_total += got;
                end
        end
        res.max_flow = flow_total[FLOW_W-1:0];
        res.saturated = flow_ovf;
        flow_expected.push_back(res);
        clear_graph();
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // monitor: input beats feed the shadow, output beats are checked
    always @(posedge clk)
    begin
        dmf_out_t want;
        in_done <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            if (in_data.action == ACT_ADD)
                add_beats++;
            apply_beat(in_data);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (flow_expected.size() == 0)
                report("unexpected result beat", 64'(out_data), 64'd0);
            else
            begin
                want = flow_expected.pop_front();
                flows_checked++;
                if (out_data.max_flow !== want.max_flow)
                    report("max_flow", 64'(out_data.max_flow), 64'(want.max_flow));
                if (out_data.saturated !== want.saturated)
                    report("saturated", 64'(out_data.saturated), 64'(want.saturated));
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > QUIET_MAX)
        begin
            $display("timeout: no beat for %0d cycles", quiet);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // driver: payload holds until the beat is taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_done))
        begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                in_valid <= 1'b1;
                in_data <= pending_beats.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= rst_n && hold_cnt == 0 && $urandom_range(99) >= recv_stall;
    end

    task automatic cfg_write(dmf_reg_t idx, int unsigned val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_NODE_COUNT: node_limit = val & 7'h7F;
            REG_SOURCE:     src_node = val & 6'h3F;
            default:        snk_node = val & 6'h3F;
        endcase
    endtask

    task automatic set_graph_cfg(int unsigned n, int unsigned s, int unsigned t);
        cfg_write(REG_NODE_COUNT, n);
        cfg_write(REG_SOURCE, s);
        cfg_write(REG_SINK, t);
    endtask

    task automatic queue_add(int unsigned a, int unsigned b, logic [31:0] cap);
        dmf_in_t it;
        it.action = ACT_ADD;
        it.from_node = a[5:0];
        it.to_node = b[5:0];
        it.capacity = cap;
        pending_beats.push_back(it);
    endtask

    task automatic queue_compute();
        dmf_in_t it;
        it.action = ACT_COMPUTE;
        it.from_node = NODE_W'($urandom_range(63));
        it.to_node = NODE_W'($urandom_range(63));
        it.capacity = $urandom;
        pending_beats.push_back(it);
    endtask

    // random graph: mostly edges inside the used range, a few beyond it
    task automatic queue_graph(int unsigned n);
        int unsigned edges;
        int unsigned a;
        int unsigned b;
        logic [31:0] cap;
        int unsigned span;
        span = (n == 0) ? 1 : ((n > NODES) ? NODES : n);
        edges = $urandom_range(6, 22);
        for (int i = 0; i < edges; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                a = $urandom_range(63);
                b = $urandom_range(63);
            end
            else if ($urandom_range(3) == 0)
            begin
                a = src_node;
                b = $urandom_range(span - 1);
            end
            else if ($urandom_range(3) == 0)
            begin
                a = $urandom_range(span - 1);
                b = snk_node;
            end
            else
            begin
                a = $urandom_range(span - 1);
                b = $urandom_range(span - 1);
            end
            case ($urandom_range(4))
                0:       cap = $urandom;
                1:       cap = 32'hFFFF_FFFF;
                2:       cap = 0;
                default: cap = $urandom_range(1, 1000);
            endcase
            queue_add(a, b, cap);
        end
        queue_compute();
    endtask

    task automatic drain();
        while (pending_beats.size() != 0 || in_valid || flow_expected.size() != 0)
            @(posedge clk);
        repeat (SWEEP_WAIT) @(posedge clk);
    endtask

    task automatic random_cfg();
        int unsigned n;
        int unsigned span;
        case ($urandom_range(9))
            0:       n = 64;
            1:       n = $urandom_range(65, 127);
            2:       n = $urandom_range(0, 1);
            3:       n = $urandom_range(9, 63);
            default: n = $urandom_range(2, 8);
        endcase
        span = (n > NODES) ? NODES : ((n == 0) ? 1 : n);
        if ($urandom_range(11) == 0)
            set_graph_cfg(n, $urandom_range(63), $urandom_range(63));
        else
            set_graph_cfg(n, $urandom_range(span - 1), $urandom_range(span - 1));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_done = 1'b0;
        errors = 0;
        add_beats = 0;
        flows_checked = 0;
        send_idle = 0;
        recv_stall = 0;
        hold_cnt = 0;
        quiet = 0;
        node_limit = 64;
        src_node = 0;
        snk_node = 1;
        clear_graph();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed: widest capacities, parallel paths, stray edges
        queue_add(0, 1, 32'hFFFF_FFFF);
        queue_add(0, 1, 32'hFFFF_FFFF);
        queue_add(0, 2, 5);
        queue_add(2, 1, 7);
        queue_add(63, 62, 32'hAAAA_5555);
        queue_add(2, 3, 0);
        queue_compute();
        queue_compute();
        drain();
        // source equal to sink
        set_graph_cfg(64, 5, 5);
        queue_add(5, 6, 9);
        queue_compute();
        drain();
        // no nodes in use, then node count above the matrix
        set_graph_cfg(0, 0, 1);
        queue_compute();
        drain();
        set_graph_cfg(127, 63, 0);
        queue_add(63, 10, 32'h5555_AAAA);
        queue_add(10, 0, 32'h0000_FFFF);
        queue_add(63, 0, 3);
        queue_compute();
        drain();
        // sink beyond node count, edges beyond it kept but unused
        set_graph_cfg(4, 0, 9);
        queue_add(0, 9, 100);
        queue_add(1, 2, 100);
        queue_compute();
        drain();
        set_graph_cfg(1, 0, 0);
        queue_compute();
        drain();

        for (int ph = 0; ph < 18; ph++)
        begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 82; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 82; end
                default: begin send_idle = 19; recv_stall = 19; end
            endcase
            random_cfg();
            for (int g = 0; g < 4; g++)
                queue_graph(node_limit);
            drain();
        end

        // receiver held off while several graphs are offered back to back
        send_idle = 0;
        recv_stall = 0;
        set_graph_cfg(6, 0, 5);
        @(negedge clk);
        hold_cnt = 30000;
        for (int g = 0; g < 4; g++)
            queue_graph(6);
        drain();

        $display("covered %0d add beats and %0d flow results", add_beats, flows_checked);
        $display("over directed corner cases, 18 random phases and one long receiver stall");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
